[sv/rgb_ratio_window_colour_classifier_defines.svh]
// ----------------------------------------------------------------------------
// Colour classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_RATIO_WINDOW_COLOUR_CLASSIFIER_DEFINES_SVH
`define RGB_RATIO_WINDOW_COLOUR_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGBRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rgbrc_pkg.sv]
// ----------------------------------------------------------------------------
// Colour classifier package
// Widths, register map, class codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbrc_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int RATIO_FRAC_BITS = 8;
  localparam int RATIO_BITS      = 16;
  localparam int COUNT_BITS      = 16;
  localparam int NUM_W           = SAMPLE_BITS + RATIO_FRAC_BITS;
  localparam int QUO_W           = (NUM_W > RATIO_BITS) ? NUM_W : RATIO_BITS;
  localparam int CNT_W           = $clog2(NUM_W + 1);
  localparam int MATCH_NEEDED    = 3;
  localparam int CLASS_COUNT     = 4;
  localparam int RATIO_COUNT     = 3;

  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  localparam int REG_BLACK_A   = 0;
  localparam int REG_BLACK_B   = 1;
  localparam int REG_BLUE_A    = 2;
  localparam int REG_BLUE_B    = 3;
  localparam int REG_REFLECT_A = 4;
  localparam int REG_REFLECT_B = 5;
  localparam int REG_WHITE_A   = 6;
  localparam int REG_WHITE_B   = 7;

  localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;

  typedef enum logic [2:0] {
    CLS_BLACK   = 3'd0,
    CLS_BLUE    = 3'd1,
    CLS_REFLECT = 3'd2,
    CLS_WHITE   = 3'd3,
    CLS_UNKNOWN = 3'd4,
    CLS_NONE    = 3'd5
  } cls_t;

  typedef enum logic [1:0] {
    RT_RG = 2'd0,
    RT_RB = 2'd1,
    RT_GB = 2'd2
  } ratio_sel_t;

  typedef struct packed {
    logic                  valid;
    logic [RATIO_BITS-1:0] value;
  } ratio_t;

endpackage

[sv/rgbrc_if.sv]
// ----------------------------------------------------------------------------
// Colour classifier channels
// Valid/ready channels for sensor readings and for classification results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgbrc_in_if;
  logic        valid;
  logic        ready;
  logic        fresh;
  logic [15:0] red_count;
  logic [15:0] green_count;
  logic [15:0] blue_count;
  logic [15:0] clear_count;

  modport source (output valid, fresh, red_count, green_count, blue_count, clear_count,
                  input ready);
  modport sink (input valid, fresh, red_count, green_count, blue_count, clear_count,
                output ready);
endinterface

interface rgbrc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] floor_class;
  logic [2:0] last_known_class;
  logic       updated;

  modport source (output valid, floor_class, last_known_class, updated, input ready);
  modport sink (input valid, floor_class, last_known_class, updated, output ready);
endinterface

[sv/rgbrc_div_serial.sv]
// ----------------------------------------------------------------------------
// Bit-serial ratio divider
// Restoring division, one quotient bit per cycle, with saturation to the
// ratio width and a zero-divisor flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbrc_div_serial import rgbrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [NUM_W-1:0]       num,
  input  logic [SAMPLE_BITS-1:0] den,
  output logic                   busy,
  output logic                   done,
  output ratio_t                 ratio
);

  // The numerator shifts out at the top while quotient bits shift in below.
  logic [NUM_W-1:0]       quo_r, quo_nxt;
  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;

  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   diff;
  logic                   ge;
  logic [QUO_W-1:0]       q_ext;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign q_ext       = QUO_W'(quo_r);
  assign ratio.valid = |den_r;
  assign ratio.value = (q_ext > QUO_W'(RATIO_MAX)) ? RATIO_MAX : q_ext[RATIO_BITS-1:0];
  assign busy        = (cnt_r != '0);
  assign done        = done_r;

endmodule

[sv/rgb_ratio_window_colour_classifier.sv]
// ----------------------------------------------------------------------------
// RGB ratio window colour classifier
// A fresh reading is accepted in idle; then, for each of the three ratios, the shared
// one-bit-per-cycle divider is started and run, and its result is window-tested;
// the result is then emitted. A held reading goes from idle straight to emit.
// Readings are taken only in idle, once the last one is emitted; output stalls hold emit.
// Reset clears all windows to zero and both held classes to the never-updated code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_ratio_window_colour_classifier_defines.svh"

module rgb_ratio_window_colour_classifier import rgbrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rgbrc_in_if.sink             in_if,
  rgbrc_out_if.source          out_if,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DIV   = 5'b00100,
    S_TEST  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  ratio_sel_t             ratio_sel_r, ratio_sel_nxt;
  logic [CLASS_COUNT-1:0][RATIO_COUNT-1:0] hit_r, hit_nxt;
  logic [CLASS_COUNT-1:0] hit_now;

  logic [REG_W-1:0]       win_r [NUM_REGS];

  logic                   fresh_r;
  logic [SAMPLE_BITS-1:0] red_r, green_r, blue_r;
  logic [COUNT_BITS-1:0]  clear_r;

  cls_t                   held_class_r, held_known_r;
  logic                   out_valid_r;
  cls_t                   floor_r, known_r;
  logic                   updated_r;
  logic                   out_free;

  logic                   div_start, div_busy, div_done;
  logic [NUM_W-1:0]       div_num;
  logic [SAMPLE_BITS-1:0] div_den;
  ratio_t                 div_ratio;

  logic                   black_ok, blue_ok, refl_ok, white_ok;
  cls_t                   cls_new;

  function automatic logic at_least_needed(input logic [3:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      n = n + 3'(v[i]);
    end
    return n >= 3'(MATCH_NEEDED);
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cfg_we) begin
      win_r[cfg_index] <= cfg_wdata;
    end
  end

  // Operand selection for the shared divider.
  always_comb begin
    unique case (ratio_sel_r)
      RT_RG: begin
        div_num = NUM_W'(red_r) << RATIO_FRAC_BITS;
        div_den = green_r;
      end
      RT_RB: begin
        div_num = NUM_W'(red_r) << RATIO_FRAC_BITS;
        div_den = blue_r;
      end
      RT_GB: begin
        div_num = NUM_W'(green_r) << RATIO_FRAC_BITS;
        div_den = blue_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  rgbrc_div_serial u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .ratio (div_ratio)
  );

  // Open-window test of the finished ratio against every class.
  always_comb begin : window_test
    logic [REG_W-1:0]      win_a;
    logic [REG_W-1:0]      win_b;
    logic [RATIO_BITS-1:0] lo;
    logic [RATIO_BITS-1:0] hi;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      win_a = win_r[REG_IDX_W'(2 * c)];
      win_b = win_r[REG_IDX_W'(2 * c + 1)];
      unique case (ratio_sel_r)
        RT_RG: begin
          lo = win_a[15:0];
          hi = win_a[31:16];
        end
        RT_RB: begin
          lo = win_a[47:32];
          hi = win_a[63:48];
        end
        RT_GB: begin
          lo = win_b[15:0];
          hi = win_b[31:16];
        end
        default: begin
          lo = '0;
          hi = '0;
        end
      endcase
      hit_now[c] = div_ratio.valid && (div_ratio.value > lo) && (div_ratio.value < hi);
    end
  end

  // Class decision from the stored window hits and the clear channel.
  always_comb begin
    black_ok = at_least_needed({hit_r[0], clear_r < win_r[REG_BLACK_B][47:32]});
    blue_ok  = &hit_r[1];
    refl_ok  = (&hit_r[2]) && (clear_r > win_r[REG_REFLECT_B][47:32])
               && (clear_r < win_r[REG_REFLECT_B][63:48]);
    white_ok = at_least_needed({hit_r[3], clear_r > win_r[REG_WHITE_B][47:32]});
    priority if (black_ok) begin
      cls_new = CLS_BLACK;
    end else if (blue_ok) begin
      cls_new = CLS_BLUE;
    end else if (refl_ok) begin
      cls_new = CLS_REFLECT;
    end else if (white_ok) begin
      cls_new = CLS_WHITE;
    end else begin
      cls_new = CLS_UNKNOWN;
    end
  end

  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt     = state_r;
    ratio_sel_nxt = ratio_sel_r;
    hit_nxt       = hit_r;
    div_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ratio_sel_nxt = RT_RG;
        if (in_if.valid) begin
          state_nxt = in_if.fresh ? S_START : S_EMIT;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
          hit_nxt[c][ratio_sel_r] = hit_now[c];
        end
        if (ratio_sel_r == RT_GB) begin
          state_nxt = S_EMIT;
        end else begin
          ratio_sel_nxt = (ratio_sel_r == RT_RG) ? RT_RB : RT_GB;
          state_nxt     = S_START;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_if.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ratio_sel_r  <= RT_RG;
      held_class_r <= CLS_NONE;
      held_known_r <= CLS_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ratio_sel_r <= ratio_sel_nxt;
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        if (fresh_r) begin
          held_class_r <= cls_new;
          if (cls_new != CLS_UNKNOWN) begin
            held_known_r <= cls_new;
          end
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reading and result payload.
  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (in_if.valid && in_if.ready) begin
      fresh_r <= in_if.fresh;
      red_r   <= SAMPLE_BITS'(in_if.red_count);
      green_r <= SAMPLE_BITS'(in_if.green_count);
      blue_r  <= SAMPLE_BITS'(in_if.blue_count);
      clear_r <= COUNT_BITS'(SAMPLE_BITS'(in_if.clear_count));
    end
    if (state_r == S_EMIT && out_free) begin
      updated_r <= fresh_r;
      if (fresh_r) begin
        floor_r <= cls_new;
        known_r <= (cls_new != CLS_UNKNOWN) ? cls_new : held_known_r;
      end else begin
        floor_r <= held_class_r;
        known_r <= held_known_r;
      end
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.floor_class      = floor_r;
  assign out_if.last_known_class = known_r;
  assign out_if.updated          = updated_r;

  `RGBRC_ASSERT_IMPL(a_div_idle_at_start, state_r == S_START, !div_busy,
                     "divider started while busy")
  `RGBRC_ASSERT_NEXT(a_div_loads, div_start, div_busy,
                     "divider did not take the operands")
  `RGBRC_ASSERT_IMPL(a_done_in_div, div_done, state_r == S_DIV,
                     "divider finished outside a division")
  `RGBRC_ASSERT_IMPL(a_known_not_unknown, 1'b1, held_known_r != CLS_UNKNOWN,
                     "unknown held as known class")
  `RGBRC_ASSERT_IMPL(a_pending_matches_held, out_valid_r && updated_r,
                     held_class_r == floor_r, "held class differs from pending result")

endmodule
